[rtl/cbfc_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the frame checker.
`timescale 1ns / 1ps

package cbfc_pkg;

   localparam logic [15:0] CRC_POLY = 16'h3D65;

   localparam logic [7:0] START_BYTE0 = 8'h05;
   localparam logic [7:0] START_BYTE1 = 8'h64;
   localparam logic [7:0] REQ_MASK    = 8'hC0;
   localparam logic [7:0] REQ_MATCH   = 8'h80;
   localparam logic [7:0] REQ_ADDR    = 8'h3F;

   // Header length covers control, address and channel.
   localparam logic [7:0] HDR_OVERHEAD = 8'd3;
   // Messages shorter than this cannot hold a full frame.
   localparam logic [8:0] MIN_FRAME_BYTES = 9'd8;
   localparam logic [8:0] POS_MAX = 9'd511;

   localparam logic ITEM_DATA   = 1'b0;
   localparam logic ITEM_STATUS = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_REQUEST   = 3'd1;
   localparam logic [2:0] STATUS_BAD_BYTE  = 3'd2;
   localparam logic [2:0] STATUS_SHORT     = 3'd3;
   localparam logic [2:0] STATUS_NO_START  = 3'd4;
   localparam logic [2:0] STATUS_BAD_FRAME = 3'd5;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] data_byte;
      logic [2:0] status;
      logic [7:0] frame_length;
      logic [7:0] control;
      logic [7:0] address;
      logic [7:0] channel;
   } cbfc_rsp_type;

   // CRC-16, most significant bit first, one received byte per call.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[rtl/cbfc_if.sv]
// Valid/ready channel interfaces for received bytes and result items.
`timescale 1ns / 1ps

interface cbfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_message;

   modport source (output valid, output rx_byte, output end_of_message, input ready);
   modport sink (input valid, input rx_byte, input end_of_message, output ready);
endinterface

interface cbfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] data_byte;
   logic [2:0] status;
   logic [7:0] frame_length;
   logic [7:0] control;
   logic [7:0] address;
   logic [7:0] channel;

   modport source (output valid, output item_kind, output data_byte, output status,
                   output frame_length, output control, output address, output channel,
                   input ready);
   modport sink (input valid, input item_kind, input data_byte, input status,
                 input frame_length, input control, input address, input channel,
                 output ready);
endinterface

[rtl/cbfc_parser.sv]
// Frame parser: per-message state, CRC check and result item formation.
`timescale 1ns / 1ps

module cbfc_parser #(
   parameter int BLOCK_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            rx_byte,
   input  logic                  end_of_message,
   output logic                  rsp_push,
   output cbfc_pkg::cbfc_rsp_type rsp_data
);

   localparam int BW = $clog2(BLOCK_BYTES + 1);

   typedef enum logic [1:0] {
      PH_BODY,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_DONE
   } phase_type;

   logic [8:0]    pos_ff, pos_in;
   logic [7:0]    first_ff, first_in;
   logic          start_ok_ff, start_ok_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crc_lo_ff, crc_lo_in;
   logic [7:0]    hdr_ff [4];
   logic [7:0]    hdr_in [4];
   logic [7:0]    data_rem_ff, data_rem_in;
   logic [BW-1:0] block_rem_ff, block_rem_in;
   phase_type     phase_ff, phase_in;
   logic          bad_ff, bad_in;
   logic          complete_ff, complete_in;

   logic [8:0]    pos_upd;
   logic [7:0]    first_upd;
   logic          start_ok_upd;
   logic [15:0]   crc_upd;
   logic [7:0]    crc_lo_upd;
   logic [7:0]    hdr_upd [4];
   logic [7:0]    data_rem_upd;
   logic [BW-1:0] block_rem_upd;
   phase_type     phase_upd;
   logic          bad_upd;
   logic          complete_upd;
   logic          is_data;
   logic [15:0]   crc_got;
   cbfc_pkg::cbfc_rsp_type status_item;

   always_comb begin
      pos_upd       = (pos_ff == cbfc_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;
      first_upd     = first_ff;
      start_ok_upd  = start_ok_ff;
      crc_upd       = crc_ff;
      crc_lo_upd    = crc_lo_ff;
      hdr_upd       = hdr_ff;
      data_rem_upd  = data_rem_ff;
      block_rem_upd = block_rem_ff;
      phase_upd     = phase_ff;
      bad_upd       = bad_ff;
      complete_upd  = complete_ff;
      is_data       = 1'b0;
      crc_got       = {rx_byte, crc_lo_ff};

      if (pos_ff == 9'd0) begin
         first_upd = rx_byte;
      end else if (pos_ff == 9'd1) begin
         start_ok_upd = (first_ff == cbfc_pkg::START_BYTE0) &&
                        (rx_byte == cbfc_pkg::START_BYTE1);
      end else if (start_ok_ff) begin
         unique case (phase_ff)
            PH_CRC_LO: begin
               crc_lo_upd = rx_byte;
               phase_upd  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               if (crc_got != ~crc_ff) begin
                  bad_upd = 1'b1;
               end
               // Each CRC closes a block; the next block restarts the CRC from zero.
               crc_upd = 16'h0000;
               if (data_rem_ff == 8'd0) begin
                  complete_upd = 1'b1;
                  phase_upd    = PH_DONE;
               end else begin
                  block_rem_upd = (data_rem_ff < 8'(BLOCK_BYTES)) ?
                                  data_rem_ff[BW-1:0] : BW'(BLOCK_BYTES);
                  phase_upd     = PH_BODY;
               end
            end
            PH_BODY: begin
               crc_upd = cbfc_pkg::crc_feed(crc_ff, rx_byte);
               if (pos_ff < 9'd6) begin
                  hdr_upd[pos_ff[1:0] - 2'd2] = rx_byte;
                  if (pos_ff == 9'd5) begin
                     data_rem_upd = (hdr_ff[0] > cbfc_pkg::HDR_OVERHEAD) ?
                                    hdr_ff[0] - cbfc_pkg::HDR_OVERHEAD : 8'd0;
                     phase_upd    = PH_CRC_LO;
                  end
               end else begin
                  is_data       = 1'b1;
                  data_rem_upd  = data_rem_ff - 8'd1;
                  block_rem_upd = block_rem_ff - BW'(1);
                  if (block_rem_upd == '0) begin
                     phase_upd = PH_CRC_LO;
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // End-of-message verdict, taken from the state after this byte.
   always_comb begin
      status_item = '0;
      status_item.item_kind = cbfc_pkg::ITEM_STATUS;
      priority if (pos_upd == 9'd1) begin
         if ((first_upd & cbfc_pkg::REQ_MASK) == cbfc_pkg::REQ_MATCH) begin
            status_item.status       = cbfc_pkg::STATUS_REQUEST;
            status_item.frame_length = 8'd1;
            status_item.control      = first_upd;
            status_item.address      = ~first_upd & cbfc_pkg::REQ_ADDR;
         end else begin
            status_item.status = cbfc_pkg::STATUS_BAD_BYTE;
         end
      end else if (pos_upd < cbfc_pkg::MIN_FRAME_BYTES) begin
         status_item.status = cbfc_pkg::STATUS_SHORT;
      end else if (!start_ok_upd) begin
         status_item.status = cbfc_pkg::STATUS_NO_START;
      end else begin
         status_item.status       = (bad_upd || !complete_upd) ?
                                    cbfc_pkg::STATUS_BAD_FRAME : cbfc_pkg::STATUS_OK;
         status_item.frame_length = hdr_upd[0];
         status_item.control      = hdr_upd[1];
         status_item.address      = hdr_upd[2];
         status_item.channel      = hdr_upd[3];
      end
   end

   always_comb begin
      rsp_push = fire && (end_of_message || is_data);
      if (end_of_message) begin
         rsp_data = status_item;
      end else begin
         rsp_data           = '0;
         rsp_data.item_kind = cbfc_pkg::ITEM_DATA;
         rsp_data.data_byte = rx_byte;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      first_in     = first_ff;
      start_ok_in  = start_ok_ff;
      crc_in       = crc_ff;
      crc_lo_in    = crc_lo_ff;
      hdr_in       = hdr_ff;
      data_rem_in  = data_rem_ff;
      block_rem_in = block_rem_ff;
      phase_in     = phase_ff;
      bad_in       = bad_ff;
      complete_in  = complete_ff;
      if (fire) begin
         crc_lo_in = crc_lo_upd;
         if (end_of_message) begin
            pos_in       = '0;
            first_in     = '0;
            start_ok_in  = 1'b0;
            crc_in       = '0;
            hdr_in       = '{default: '0};
            data_rem_in  = '0;
            block_rem_in = '0;
            phase_in     = PH_BODY;
            bad_in       = 1'b0;
            complete_in  = 1'b0;
         end else begin
            pos_in       = pos_upd;
            first_in     = first_upd;
            start_ok_in  = start_ok_upd;
            crc_in       = crc_upd;
            hdr_in       = hdr_upd;
            data_rem_in  = data_rem_upd;
            block_rem_in = block_rem_upd;
            phase_in     = phase_upd;
            bad_in       = bad_upd;
            complete_in  = complete_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      crc_lo_ff <= crc_lo_in;
      if (reset) begin
         pos_ff       <= '0;
         first_ff     <= '0;
         start_ok_ff  <= 1'b0;
         crc_ff       <= '0;
         hdr_ff       <= '{default: '0};
         data_rem_ff  <= '0;
         block_rem_ff <= '0;
         phase_ff     <= PH_BODY;
         bad_ff       <= 1'b0;
         complete_ff  <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         start_ok_ff  <= start_ok_in;
         crc_ff       <= crc_in;
         hdr_ff       <= hdr_in;
         data_rem_ff  <= data_rem_in;
         block_rem_ff <= block_rem_in;
         phase_ff     <= phase_in;
         bad_ff       <= bad_in;
         complete_ff  <= complete_in;
      end
   end

endmodule

[rtl/cbfc_out_buffer.sv]
// Two-entry output register with skid stage for result items.
`timescale 1ns / 1ps

module cbfc_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cbfc_pkg::cbfc_rsp_type push_data,
   output logic                   space,
   output logic                   out_valid,
   output cbfc_pkg::cbfc_rsp_type out_data,
   input  logic                   out_ready
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   cbfc_pkg::cbfc_rsp_type main_data_ff, main_data_in;
   cbfc_pkg::cbfc_rsp_type skid_data_ff, skid_data_in;
   logic                   pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // A new transaction is never pushed while the skid entry is occupied.
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule

[rtl/crc16_block_frame_checker.sv]
// Top level of the CRC-16 block frame checker.
//
//   Channel    Direction  Contents
//   req_chan   in         rx_byte, end_of_message
//   rsp_chan   out        item_kind, data_byte, status, frame_length, control,
//                         address, channel
//
// One received byte is taken per clock while req_chan.ready is high; its result
// item, if any, is registered in the output stages and then shows on rsp_chan.
// The CRC update for a byte is combinational, setting the one byte per cycle rate.
// req_chan.ready falls only while both output stages hold undelivered items.
// Synchronous reset clears the parser (bar its CRC low byte) and the output stages.
`timescale 1ns / 1ps

module crc16_block_frame_checker #(
   parameter int BLOCK_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   cbfc_req_if.sink    req_chan,
   cbfc_rsp_if.source  rsp_chan
);

   logic                   fire;
   logic                   space;
   logic                   rsp_push;
   cbfc_pkg::cbfc_rsp_type rsp_data;
   cbfc_pkg::cbfc_rsp_type out_data;

   assign req_chan.ready = space;
   assign fire           = req_chan.valid && space;

   cbfc_parser #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .rx_byte        (req_chan.rx_byte),
      .end_of_message (req_chan.end_of_message),
      .rsp_push       (rsp_push),
      .rsp_data       (rsp_data)
   );

   cbfc_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.item_kind    = out_data.item_kind;
   assign rsp_chan.data_byte    = out_data.data_byte;
   assign rsp_chan.status       = out_data.status;
   assign rsp_chan.frame_length = out_data.frame_length;
   assign rsp_chan.control      = out_data.control;
   assign rsp_chan.address      = out_data.address;
   assign rsp_chan.channel      = out_data.channel;

endmodule
